// ----- design/snf_pkg.sv -----
// Shared types, constants and segment table for the seven-segment number formatter.
package snf_pkg;

  localparam int DIGITS   = 4;
  localparam int SEG_W    = 8;
  localparam int DATA_W   = DIGITS * SEG_W;
  localparam int IN_W     = 32;

  // Digit codes: 0-9 are decimal digits, then blank and minus
  typedef logic [3:0] code_t;
  localparam code_t CODE_BLANK = 4'd10;
  localparam code_t CODE_MINUS = 4'd11;

  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

  // Accepted ranges
  localparam logic signed [15:0] VALUE_MAX = 16'sd9999;
  localparam logic signed [15:0] VALUE_MIN = -16'sd999;
  localparam logic [7:0]         CLOCK_MAX = 8'd99;

  // Digit codes of one word, digit 0 is the leftmost
  typedef struct packed {
    code_t [DIGITS-1:0] code;
    logic               ok;
  } split_t;

  // Segment pattern of one digit code, bits 0-6 are segments a-g
  function automatic logic [SEG_W-1:0] seg_of(input code_t c);
    logic [SEG_W-1:0] s;
    unique case (c)
      4'd0:       s = 8'h3F;
      4'd1:       s = 8'h06;
      4'd2:       s = 8'h5B;
      4'd3:       s = 8'h4F;
      4'd4:       s = 8'h66;
      4'd5:       s = 8'h6D;
      4'd6:       s = 8'h7D;
      4'd7:       s = 8'h07;
      4'd8:       s = 8'h7F;
      4'd9:       s = 8'h6F;
      CODE_MINUS: s = 8'h40;
      default:    s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- design/snf_digit_split.sv -----
// Range check, decimal digit split and leading-zero blanking for both display modes.
module snf_digit_split (
  input  logic                 mode,
  input  logic signed [15:0]   value,
  input  logic [7:0]           hours,
  input  logic [7:0]           minutes,
  output snf_pkg::split_t      split
);

  // Count the multiples of scale that fit in x, nine parallel compares
  function automatic logic [3:0] dec_digit(input logic [13:0] x, input logic [13:0] scale);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 14'(k) * scale) d = 4'(k);
    end
    return d;
  endfunction

  logic        neg;
  logic [15:0] mag16;
  logic [13:0] mag;
  logic        int_ok;
  logic [3:0]  d_th, d_hu, d_te, d_un;
  logic [13:0] rem_hu, rem_te, rem_un;
  logic        clk_ok;
  logic [3:0]  h_te, h_un, m_te, m_un;
  logic [13:0] h_rem, m_rem;

  // Magnitude and range in integer mode
  assign neg    = value[15];
  assign mag16  = neg ? 16'(-value) : 16'(value);
  assign mag    = mag16[13:0];
  assign int_ok = (value <= snf_pkg::VALUE_MAX) && (value >= snf_pkg::VALUE_MIN);

  // Thousands, hundreds, tens, units
  assign d_th   = dec_digit(mag, 14'd1000);
  assign rem_hu = mag - {10'd0, d_th} * 14'd1000;
  assign d_hu   = dec_digit(rem_hu, 14'd100);
  assign rem_te = rem_hu - {10'd0, d_hu} * 14'd100;
  assign d_te   = dec_digit(rem_te, 14'd10);
  assign rem_un = rem_te - {10'd0, d_te} * 14'd10;
  assign d_un   = rem_un[3:0];

  // Tens and units of hours and minutes
  assign clk_ok = (hours <= snf_pkg::CLOCK_MAX) && (minutes <= snf_pkg::CLOCK_MAX);
  assign h_te   = dec_digit({6'd0, hours}, 14'd10);
  assign h_rem  = {6'd0, hours} - {10'd0, h_te} * 14'd10;
  assign h_un   = h_rem[3:0];
  assign m_te   = dec_digit({6'd0, minutes}, 14'd10);
  assign m_rem  = {6'd0, minutes} - {10'd0, m_te} * 14'd10;
  assign m_un   = m_rem[3:0];

  // Blank leading zeros, place the minus before the first significant digit
  always_comb begin
    split.code[0] = d_th;
    split.code[1] = d_hu;
    split.code[2] = d_te;
    split.code[3] = d_un;
    if (mode) begin
      split.ok      = clk_ok;
      split.code[0] = (h_te == 4'd0) ? snf_pkg::CODE_BLANK : h_te;
      split.code[1] = h_un;
      split.code[2] = m_te;
      split.code[3] = m_un;
    end else begin
      split.ok = int_ok;
      if (!neg) begin
        if (d_th == 4'd0) begin
          split.code[0] = snf_pkg::CODE_BLANK;
          if (d_hu == 4'd0) begin
            split.code[1] = snf_pkg::CODE_BLANK;
            if (d_te == 4'd0) split.code[2] = snf_pkg::CODE_BLANK;
          end
        end
      end else begin
        // Accepted magnitude stays below 1000, so the thousands place is free
        if (d_hu != 4'd0) begin
          split.code[0] = snf_pkg::CODE_MINUS;
        end else if (d_te != 4'd0) begin
          split.code[0] = snf_pkg::CODE_BLANK;
          split.code[1] = snf_pkg::CODE_MINUS;
        end else begin
          split.code[0] = snf_pkg::CODE_BLANK;
          split.code[1] = snf_pkg::CODE_BLANK;
          split.code[2] = snf_pkg::CODE_MINUS;
        end
      end
    end
  end

endmodule

// ----- design/snf_seg_encode.sv -----
// Segment encoding of four digit codes, with point bit and reject blanking.
module snf_seg_encode (
  input  snf_pkg::split_t               split,
  input  logic                          dot_en,
  output logic [snf_pkg::DATA_W-1:0]    segments
);

  // Map each digit, zero everything on a rejected word
  always_comb begin
    for (int i = 0; i < snf_pkg::DIGITS; i++) begin
      if (split.ok) begin
        segments[i*snf_pkg::SEG_W +: snf_pkg::SEG_W] =
          snf_pkg::seg_of(split.code[i]) | (dot_en ? snf_pkg::POINT_BIT : 8'h00);
      end else begin
        segments[i*snf_pkg::SEG_W +: snf_pkg::SEG_W] = '0;
      end
    end
  end

endmodule

// ----- design/seven_segment_number_formatter.sv -----
// Seven-segment number formatter: top level with input register, result register and config.
// Takes one word per clock and returns one result word per clock while out_tready is high:
// the input word is captured in an input register, then digit split, blanking
// and segment lookup run in one pass into the result register. A waiting result holds the
// result register; the input register still takes a word while it is empty, and in_tready
// follows out_tready combinationally once both registers are full. Rejected inputs (integer
// outside -999..9999, hours or minutes above 99) give all-zero segments and out_tuser low.
// cfg_data sets the point bit on every digit of accepted results and is always ready.
module seven_segment_number_formatter (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: value[15:0], hours[23:16], minutes[31:24]
  input  logic [31:0] in_tdata,
  // in_tuser: mode (0 integer, 1 hours:minutes)
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: digit0_segments[7:0], digit1_segments[15:8],
  //            digit2_segments[23:16], digit3_segments[31:24]
  output logic [31:0] out_tdata,
  // out_tuser: accepted
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_mode_r;
  logic [31:0]                    s1_data_r;
  logic                           dot_en_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [snf_pkg::DATA_W-1:0]     out_data_r;
  logic                           out_user_r;
  logic                           out_adv;
  snf_pkg::split_t                split;
  logic [snf_pkg::DATA_W-1:0]     segments;

  // Advance when the result register is empty or being taken
  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dot_en_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) dot_en_r <= cfg_data;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  snf_digit_split u_split (
    .mode    (s1_mode_r),
    .value   (s1_data_r[15:0]),
    .hours   (s1_data_r[23:16]),
    .minutes (s1_data_r[31:24]),
    .split   (split)
  );

  snf_seg_encode u_encode (
    .split    (split),
    .dot_en   (dot_en_r),
    .segments (segments)
  );

  // Load the result word
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= segments;
      out_user_r <= split.ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- design/snf_checker.sv -----
// Port-level checker for the seven-segment number formatter, bound to the top level.
module snf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tvalid,
  input logic        out_tready
);

  // Rejected words carry no lit segment
  a_reject_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("rejected word has lit segments");

  // Rightmost digit is always a lit digit on accepted words
  a_units_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[30:24] != 7'd0)
    else $error("rightmost digit blank on accepted word");

  // Point bit is the same on all four digits
  a_point_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[7] == out_tdata[15]) &&
      (out_tdata[15] == out_tdata[23]) && (out_tdata[23] == out_tdata[31]))
    else $error("point bit differs between digits");

  // A new result follows an accepted input word through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching input word");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind seven_segment_number_formatter snf_checker u_snf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
